/* hw/rtl/dro_pkg.sv */
// Package for the dead reckoning odometry block: widths, codes, CORDIC table.
// No dependencies.
package dro_pkg;
  localparam int CORDIC_STEPS_DEF = 24;
  localparam logic [1:0] ACT_SETVEL  = 2'd0;
  localparam logic [1:0] ACT_TICK    = 2'd1;
  localparam logic [1:0] ACT_RESTART = 2'd2;
  localparam logic [1:0] ACT_UNUSED  = 2'd3;
  localparam logic [1:0] REG_PERIOD  = 2'd0;
  localparam logic [1:0] REG_RATE    = 2'd1;
  localparam logic [1:0] REG_HEAD    = 2'd2;
  localparam logic [1:0] REG_UNUSED  = 2'd3;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE, OP_SETVEL, OP_RESTART, OP_CINIT, OP_CSTEP, OP_MUL_A, OP_MUL_B,
    OP_MUL_C, OP_HEAD, OP_QINIT, OP_QFIN, OP_ACC
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [4:0] idx;
  } cmd_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    case (i)
      5'd0: atan_turn = 32'd536870912;  5'd1: atan_turn = 32'd316933406;
      5'd2: atan_turn = 32'd167458907;  5'd3: atan_turn = 32'd85004756;
      5'd4: atan_turn = 32'd42667331;   5'd5: atan_turn = 32'd21354465;
      5'd6: atan_turn = 32'd10679838;   5'd7: atan_turn = 32'd5340245;
      5'd8: atan_turn = 32'd2670163;    5'd9: atan_turn = 32'd1335087;
      5'd10: atan_turn = 32'd667544;    5'd11: atan_turn = 32'd333772;
      5'd12: atan_turn = 32'd166886;    5'd13: atan_turn = 32'd83443;
      5'd14: atan_turn = 32'd41722;     5'd15: atan_turn = 32'd20861;
      5'd16: atan_turn = 32'd10430;     5'd17: atan_turn = 32'd5215;
      5'd18: atan_turn = 32'd2608;      5'd19: atan_turn = 32'd1304;
      5'd20: atan_turn = 32'd652;       5'd21: atan_turn = 32'd326;
      5'd22: atan_turn = 32'd163;       5'd23: atan_turn = 32'd81;
      5'd24: atan_turn = 32'd41;        5'd25: atan_turn = 32'd20;
      5'd26: atan_turn = 32'd10;        5'd27: atan_turn = 32'd5;
      5'd28: atan_turn = 32'd3;         5'd29: atan_turn = 32'd1;
      5'd30: atan_turn = 32'd1;         default: atan_turn = 32'd0;
    endcase
  endfunction
endpackage

/* hw/rtl/dro_ctrl.sv */
// Controller for the odometry block: sequences CORDIC and multiply steps.
// Depends on dro_pkg.
module dro_ctrl import dro_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_fire,
  input  logic [1:0] in_action,
  input  logic       out_busy,
  output logic       in_ready,
  output logic       out_load,
  output cmd_t       cmd
);
  localparam logic [2:0] S_IDLE = 3'd0, S_C1 = 3'd1, S_MUL = 3'd2, S_C2 = 3'd3,
                         S_FIN = 3'd4, S_OUT = 3'd5;
  logic [2:0] state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    cmd.op = OP_NONE;
    cmd.idx = cnt_r;
    out_load = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_action)
            ACT_SETVEL: cmd.op = OP_SETVEL;
            ACT_RESTART: cmd.op = OP_RESTART;
            ACT_TICK: begin
              cmd.op = OP_CINIT;
              state_nxt = S_C1;
              cnt_nxt = '0;
            end
            default: cmd.op = OP_NONE;
          endcase
        end
      end
      S_C1: begin
        cmd.op = OP_CSTEP;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'(CORDIC_STEPS - 1)) begin
          state_nxt = S_MUL;
          cnt_nxt = '0;
        end
      end
      S_MUL: begin
        cnt_nxt = cnt_r + 5'd1;
        case (cnt_r)
          5'd0: cmd.op = OP_MUL_A;
          5'd1: cmd.op = OP_MUL_B;
          5'd2: cmd.op = OP_MUL_C;
          5'd3: cmd.op = OP_HEAD;
          default: begin
            cmd.op = OP_QINIT;
            state_nxt = S_C2;
            cnt_nxt = '0;
          end
        endcase
      end
      S_C2: begin
        cmd.op = OP_CSTEP;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'(CORDIC_STEPS - 1)) state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.op = OP_QFIN;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_busy) begin
          cmd.op = OP_ACC;
          out_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
    end
  end
endmodule

/* hw/rtl/dro_dp.sv */
// Datapath for the odometry block: state, shared CORDIC, multiplies.
// Depends on dro_pkg.
module dro_dp import dro_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  input  logic signed [23:0] vel_i [3],
  input  logic signed [23:0] rate_i [3],
  input  logic [16:0]        period,
  input  logic [18:0]        trate,
  input  logic [31:0]        init_head,
  output logic signed [47:0] pos_o [3],
  output logic signed [24:0] deg_o,
  output logic signed [31:0] qz_o,
  output logic signed [31:0] qw_o,
  output logic signed [31:0] acc_o [3],
  output logic signed [23:0] rates_o [3]
);
  logic [31:0] head_r;
  logic signed [47:0] pos_r [3];
  logic signed [23:0] vel_r [3], rts_r [3], prev_r [3];
  logic signed [33:0] x_r, y_r;
  logic signed [32:0] z_r;
  logic flip_r;
  logic signed [33:0] c_r, s_r;
  logic signed [41:0] rz_r [2];
  logic signed [41:0] ang_r;
  logic [31:0] ang_in;
  logic signed [33:0] xs, ys, xc, yc;
  logic signed [32:0] at;
  logic signed [33:0] cx, cy;
  logic signed [57:0] m0, m1, m2, m3, re, rn;
  logic signed [41:0] r32e, r32n;
  logic signed [59:0] de, dn;
  logic signed [49:0] pe, pn, pu;
  logic signed [41:0] pv;
  logic signed [64:0] hm;
  logic signed [31:0] hinc;
  logic signed [31:0] hs;

  function automatic logic signed [33:0] clip(input logic signed [33:0] v);
    if (v > ONE_Q30) clip = ONE_Q30;
    else if (v < -ONE_Q30) clip = -ONE_Q30;
    else clip = v;
  endfunction
  function automatic logic signed [47:0] psat(input logic signed [49:0] v);
    if (v > 50'sh7FFFFFFFFFFF) psat = 48'sh7FFFFFFFFFFF;
    else if (v < -50'sh800000000000) psat = 48'sh800000000000;
    else psat = v[47:0];
  endfunction

  assign hs = $signed(head_r) >>> 1;
  assign ang_in = (cmd.op == OP_QINIT) ? hs : head_r;
  assign xs = x_r >>> cmd.idx;
  assign ys = y_r >>> cmd.idx;
  assign at = $signed({1'b0, atan_turn(cmd.idx)});
  assign cx = flip_r ? -x_r : x_r;
  assign cy = flip_r ? -y_r : y_r;
  assign xc = clip(cx);
  assign yc = clip(cy);

  // rotated velocity products, all four formed combinationally
  assign m0 = vel_r[0] * c_r;
  assign m1 = vel_r[1] * s_r;
  assign m2 = vel_r[0] * s_r;
  assign m3 = vel_r[1] * c_r;
  assign re = m0 - m1;
  assign rn = m2 + m3;
  // Q32 rotated velocity can reach 2^40, keep the full width
  assign r32e = 42'((re + 58'sd8192) >>> 14);
  assign r32n = 42'((rn + 58'sd8192) >>> 14);
  assign de = (rz_r[0] * $signed({1'b0, period}) + 60'sh80000000) >>> 32;
  assign dn = (rz_r[1] * $signed({1'b0, period}) + 60'sh80000000) >>> 32;
  assign pv = vel_r[2] * $signed({1'b0, period});
  assign pe = pos_r[0] + 50'(de);
  assign pn = pos_r[1] + 50'(dn);
  assign pu = pos_r[2] + 50'((pv + 42'sd32768) >>> 16);
  assign hm = ang_r * 65'sd2670177 + 65'sh800000;
  assign hinc = 32'(hm >>> 24);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      for (int k = 0; k < 3; k++) begin
        pos_r[k] <= '0; vel_r[k] <= '0; rts_r[k] <= '0; prev_r[k] <= '0;
      end
    end else begin
      case (cmd.op)
        OP_SETVEL: for (int k = 0; k < 3; k++) begin
          vel_r[k] <= vel_i[k]; rts_r[k] <= rate_i[k];
        end
        OP_RESTART: begin
          head_r <= init_head;
          for (int k = 0; k < 3; k++) begin
            pos_r[k] <= '0; vel_r[k] <= '0; rts_r[k] <= '0; prev_r[k] <= '0;
          end
        end
        OP_MUL_B: begin
          pos_r[2] <= psat(pu);
        end
        OP_MUL_C: begin
          pos_r[0] <= psat(pe);
          pos_r[1] <= psat(pn);
        end
        OP_HEAD: head_r <= head_r + hinc;
        OP_ACC: for (int k = 0; k < 3; k++) prev_r[k] <= vel_r[k];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_CINIT, OP_QINIT: begin
        flip_r <= ang_in[31] ^ ang_in[30];
        x_r <= CORDIC_GAIN;
        y_r <= '0;
        z_r <= $signed({ang_in[31] ^ (ang_in[31] ^ ang_in[30]), ang_in[31] ^ (ang_in[31] ^
                ang_in[30]), ang_in[30:0]});
      end
      OP_CSTEP: begin
        if (!z_r[32]) begin
          x_r <= x_r - ys; y_r <= y_r + xs; z_r <= z_r - at;
        end else begin
          x_r <= x_r + ys; y_r <= y_r - xs; z_r <= z_r + at;
        end
      end
      OP_MUL_A: begin
        c_r <= xc; s_r <= yc;
        ang_r <= rts_r[2] * $signed({1'b0, period});
      end
      OP_MUL_B: begin
        rz_r[0] <= r32e; rz_r[1] <= r32n;
      end
      OP_QFIN: begin
        qw_o <= 32'(xc); qz_o <= 32'(yc);
        deg_o <= 25'(($signed(head_r) * 42'sd45 + 42'sd4096) >>> 13);
      end
      default: ;
    endcase
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic signed [45:0] a;
      logic signed [45:0] sh;
      a = (vel_r[k] - prev_r[k]) * $signed({1'b0, trate}) + 46'sd128;
      sh = a >>> 8;
      if (sh > 46'sh7FFFFFFF) acc_o[k] = 32'h7FFFFFFF;
      else if (sh < -46'sh80000000) acc_o[k] = 32'h80000000;
      else acc_o[k] = sh[31:0];
      pos_o[k] = pos_r[k];
      rates_o[k] = rts_r[k];
    end
  end
endmodule

/* hw/rtl/dead_reckoning_odometry.sv */
// Dead reckoning odometry top level: stream ports, config regs, output reg.
// A tick runs the shared CORDIC twice, with the multiply and heading steps between;
// its result is loaded into the output register once that register is free, and no new
// item is taken until then; set-velocity and restart finish without leaving idle.
// One item at a time; the result register frees the core once loaded.
// Synchronous active-low reset clears state and loads register defaults.
module dead_reckoning_odometry import dro_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // action[1:0], vel_x, vel_y, vel_z, rate_x, rate_y, rate_z (24 each)
  input  logic [151:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // pos_east, pos_north, pos_up (48), heading_deg (25), quat_z, quat_w,
  // accel_x, accel_y, accel_z (32), rate_roll, rate_pitch, rate_yaw (24)
  output logic [407:0] out_tdata,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_wdata
);
  logic [16:0] period_r;
  logic [18:0] trate_r;
  logic [31:0] head_r;
  logic in_fire, out_load;
  cmd_t cmd;
  logic signed [23:0] vel_i [3], rate_i [3], rates [3];
  logic signed [47:0] pos [3];
  logic signed [31:0] acc [3];
  logic signed [24:0] deg;
  logic signed [31:0] qz, qw;
  logic [407:0] odata_r;
  logic ovalid_r;

  assign in_fire = in_tvalid && in_tready;
  for (genvar k = 0; k < 3; k++) begin : g_in
    assign vel_i[k] = in_tdata[2 + 24*k +: 24];
    assign rate_i[k] = in_tdata[74 + 24*k +: 24];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= 17'd6554; trate_r <= 19'd2560; head_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PERIOD: period_r <= cfg_wdata[16:0];
        REG_RATE:   trate_r <= cfg_wdata[18:0];
        REG_HEAD:   head_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  dro_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
    .clk, .rst_n, .in_fire, .in_action(in_tdata[1:0]),
    .out_busy(ovalid_r && !out_tready), .in_ready(in_tready), .out_load, .cmd
  );

  dro_dp u_dp (
    .clk, .rst_n, .cmd, .vel_i, .rate_i, .period(period_r), .trate(trate_r),
    .init_head(head_r), .pos_o(pos), .deg_o(deg), .qz_o(qz), .qw_o(qw),
    .acc_o(acc), .rates_o(rates)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) ovalid_r <= 1'b0;
    else if (out_load) ovalid_r <= 1'b1;
    else if (out_tready) ovalid_r <= 1'b0;
    if (out_load)
      odata_r <= {7'd0, rates[2], rates[1], rates[0], acc[2], acc[1], acc[0], qw, qz,
                  deg, pos[2], pos[1], pos[0]};
  end
  assign out_tvalid = ovalid_r;
  assign out_tdata = odata_r;
endmodule
